### rtl/esc_hup_pkg.sv
// Package for the escape hang-up detector.
// Character codes, reset value of the guard register and the result struct.
// No dependencies.
package esc_hup_pkg;

  localparam logic [7:0]  PLUS_CHAR   = 8'h2B;
  localparam logic [7:0]  RETURN_CHAR = 8'h0D;
  localparam logic [7:0]  CHAR_A      = 8'h41;
  localparam logic [7:0]  CHAR_T      = 8'h54;
  localparam logic [7:0]  CHAR_H      = 8'h48;
  localparam logic [15:0] GUARD_RESET = 16'd900;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic        hang_up;
    logic        rejected;
    logic [31:0] guard_delay;
  } esc_hup_res_t;

endpackage

### rtl/esc_hup_core.sv
// Escape detector core: guard register, escape state and capture store.
// Computes one result per accepted beat. Depends on esc_hup_pkg.
module esc_hup_core #(
  parameter int CAPTURE_SLOTS = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_wdata,
  input  logic                    fire,
  input  logic [7:0]              data_byte,
  input  logic [31:0]             now_ms,
  output esc_hup_pkg::esc_hup_res_t res
);

  localparam int LEN_W = $clog2(CAPTURE_SLOTS + 1);
  localparam int IDX_W = $clog2(CAPTURE_SLOTS);

  logic [15:0]      guard_r;
  logic [1:0]       plus_r, plus_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [31:0]      start_r, start_nxt;
  logic [31:0]      stop_r, stop_nxt;
  logic             await_r, await_nxt;
  logic [7:0]       chars_r [CAPTURE_SLOTS];
  logic             char_we;
  logic             is_ath;
  logic [31:0]      delay;
  logic             escaped;

  assign escaped = (plus_r == 2'd3);
  assign is_ath  = (len_r >= LEN_W'(3)) && (chars_r[0] == esc_hup_pkg::CHAR_A) &&
                   (chars_r[1] == esc_hup_pkg::CHAR_T) &&
                   (chars_r[2] == esc_hup_pkg::CHAR_H);
  assign delay   = stop_r - start_r;

  always_comb begin
    plus_nxt  = plus_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    stop_nxt  = stop_r;
    await_nxt = await_r;
    char_we   = 1'b0;
    res       = '0;
    if (data_byte == esc_hup_pkg::PLUS_CHAR) begin
      start_nxt = now_ms;
      len_nxt   = '0;
      plus_nxt  = escaped ? plus_r : plus_r + 2'd1;
      await_nxt = 1'b1;
    end else if (data_byte == esc_hup_pkg::RETURN_CHAR) begin
      if (escaped && is_ath) begin
        res.hang_up     = (guard_r == 16'd0) || (delay > {16'd0, guard_r});
        res.rejected    = !res.hang_up;
        res.guard_delay = delay;
      end
      len_nxt  = '0;
      plus_nxt = 2'd0;
    end else begin
      if (escaped && (len_r < LEN_W'(CAPTURE_SLOTS))) begin
        if (await_r) begin
          stop_nxt  = now_ms;
          await_nxt = 1'b0;
        end
        char_we = 1'b1;
        len_nxt = len_r + LEN_W'(1);
      end else begin
        plus_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r <= esc_hup_pkg::GUARD_RESET;
      plus_r  <= 2'd0;
      len_r   <= '0;
      start_r <= '0;
      stop_r  <= '0;
      await_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        guard_r <= cfg_wdata;
      end
      if (fire) begin
        plus_r  <= plus_nxt;
        len_r   <= len_nxt;
        start_r <= start_nxt;
        stop_r  <= stop_nxt;
        await_r <= await_nxt;
      end
    end
  end

  // capture store: no reset, entries are read only below len_r
  always_ff @(posedge clk) begin
    if (fire && char_we) begin
      chars_r[len_r[IDX_W-1:0]] <= data_byte;
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(CAPTURE_SLOTS))
    else $error("capture length past slot count");
  a_flag_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.hang_up || res.rejected) |=> plus_r == 2'd0 && len_r == '0)
    else $error("escape state not cleared after flagged return");
  a_plus_arms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && data_byte == esc_hup_pkg::PLUS_CHAR |=> await_r && len_r == '0)
    else $error("plus did not arm stop capture");
`endif

endmodule

### rtl/esc_hup_outreg.sv
// Result register for the escape detector: holds one beat until taken.
// Frees the input side whenever the register is empty or being drained.
// Depends on esc_hup_pkg.
module esc_hup_outreg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  esc_hup_pkg::esc_hup_res_t   res,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [esc_hup_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic                      valid_r;
  esc_hup_pkg::esc_hup_res_t res_r;

  assign in_ready   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, res_r.guard_delay, res_r.rejected, res_r.hang_up};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !(res_r.hang_up && res_r.rejected))
    else $error("hang_up and rejected both set");
  a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !res_r.hang_up && !res_r.rejected |-> res_r.guard_delay == 32'd0)
    else $error("delay nonzero without flag");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> in_ready)
    else $error("empty result register blocks input");
`endif

endmodule

### rtl/escape_hangup_detector.sv
// Top level of the escape hang-up detector (+++ATH with guard time).
// Instantiates esc_hup_core and esc_hup_outreg; uses esc_hup_pkg.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    in_tdata[39:0]
//  out_     out  out_tvalid/out_tready  out_tdata[39:0]
//  cfg_     in   cfg_we                 cfg_wdata[15:0] = guard_ms
//
// One beat per cycle while in_tready is high; result is on out_ next cycle.
// The state update and flag compare (one 32-bit subtract and compare) fit
// between the state registers and the result register.
// in_tready drops only while a held result is not taken (out_tready low).
// rst_n is synchronous: guard_ms returns to 900, escape state clears;
// the capture bytes are not cleared and need no clearing pass.
module escape_hangup_detector #(
  parameter int CAPTURE_SLOTS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] data_byte, [39:8] now_ms
  input  logic [esc_hup_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] hang_up, [1] rejected, [33:2] guard_delay, rest 0
  output logic [esc_hup_pkg::OUT_DATA_W-1:0] out_tdata
);

  esc_hup_pkg::esc_hup_res_t res;
  logic                      fire;

  assign fire = in_tvalid && in_tready;

  esc_hup_core #(
    .CAPTURE_SLOTS(CAPTURE_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .data_byte (in_tdata[7:0]),
    .now_ms    (in_tdata[39:8]),
    .res       (res)
  );

  esc_hup_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
